/* hw/rtl/lwss_pkg.sv */
// ----------------------------------------------------------------------------
// lwss_pkg: shared types and constants of the link watchdog speed smoother
// Register indexes, configuration reset values, the link status record and
// the alpha saturation helper.
// ----------------------------------------------------------------------------
package lwss_pkg;

  localparam int unsigned NumWheels  = 3;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned AlphaW     = 9;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned QualityW   = 9;
  localparam int unsigned DriveW     = 16;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned OutDataW   = 64;

  localparam logic [AlphaW-1:0] AlphaOne = 9'd256;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ALPHA         = 3'd0,
    CFG_QUALITY_FLOOR = 3'd1,
    CFG_QUALITY_CEIL  = 3'd2,
    CFG_FRESH_BOOST   = 3'd3,
    CFG_DISABLE_LEVEL = 3'd4,
    CFG_ENABLE_LEVEL  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [LevelW-1:0] quality_floor;
    logic [LevelW-1:0] quality_ceiling;
    logic [LevelW-1:0] fresh_boost;
    logic [LevelW-1:0] disable_level;
    logic [LevelW-1:0] enable_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    alpha:           9'd102,
    quality_floor:   8'd5,
    quality_ceiling: 8'd100,
    fresh_boost:     8'd30,
    disable_level:   8'd30,
    enable_level:    8'd70
  };

  // link status after the current tick
  typedef struct packed {
    logic                enabled;
    logic [QualityW-1:0] quality;
  } link_status_t;

  function automatic logic [AlphaW-1:0] sat_alpha(input logic [AlphaW-1:0] a);
    sat_alpha = (a > AlphaOne) ? AlphaOne : a;
  endfunction

endpackage

/* hw/rtl/lwss_link_watch.sv */
// ----------------------------------------------------------------------------
// lwss_link_watch: link quality counter and enable flag with hysteresis
// Decrements and clamps the quality, adds the boost on a fresh command and
// updates the enable flag; state advances on each processed word.
// ----------------------------------------------------------------------------
module lwss_link_watch (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  logic                   fresh_i,
  input  lwss_pkg::cfg_t         cfg_i,
  output lwss_pkg::link_status_t status_o
);

  logic [lwss_pkg::QualityW-1:0] quality_q, quality_d;
  logic                          enabled_q, enabled_d;

  logic signed [lwss_pkg::QualityW:0] dec;
  logic signed [lwss_pkg::QualityW:0] ceil_s;
  logic signed [lwss_pkg::QualityW:0] floor_s;
  logic [lwss_pkg::LevelW-1:0]        clamped;

  always_comb begin
    dec     = $signed({1'b0, quality_q}) - 10'sd1;
    ceil_s  = $signed({2'b00, cfg_i.quality_ceiling});
    floor_s = $signed({2'b00, cfg_i.quality_floor});
    // ceiling test wins when floor sits above ceiling
    if (dec >= ceil_s) begin
      clamped = cfg_i.quality_ceiling;
    end else if (dec <= floor_s) begin
      clamped = cfg_i.quality_floor;
    end else begin
      clamped = dec[lwss_pkg::LevelW-1:0];
    end
    quality_d = {1'b0, clamped};
    if (fresh_i) begin
      quality_d = {1'b0, clamped} + {1'b0, cfg_i.fresh_boost};
    end
    if (quality_d <= {1'b0, cfg_i.disable_level}) begin
      enabled_d = 1'b0;
    end else if (quality_d >= {1'b0, cfg_i.enable_level}) begin
      enabled_d = 1'b1;
    end else begin
      enabled_d = enabled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_q <= '0;
      enabled_q <= 1'b1;
    end else if (advance_i) begin
      quality_q <= quality_d;
      enabled_q <= enabled_d;
    end
  end

  assign status_o.enabled = enabled_d;
  assign status_o.quality = quality_d;

endmodule

/* hw/rtl/lwss_filter_lane.sv */
// ----------------------------------------------------------------------------
// lwss_filter_lane: first-order smoothing filter of one wheel speed
// Moves the fixed-point state toward the target by alpha/256 with floor
// rounding; clears the state while control is disabled.
// ----------------------------------------------------------------------------
module lwss_filter_lane #(
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  logic                                enabled_i,
  input  logic [lwss_pkg::AlphaW-1:0]         alpha_i,
  input  logic signed [SPEED_BITS-1:0]        target_i,
  output logic [lwss_pkg::DriveW-1:0]         drive_o
);

  localparam int unsigned StateW = SPEED_BITS + lwss_pkg::FracBits;
  localparam int unsigned ProdW  = StateW + 1 + lwss_pkg::AlphaW + 1;
  localparam int unsigned ExtW   = (SPEED_BITS > lwss_pkg::DriveW) ? SPEED_BITS
                                                                    : lwss_pkg::DriveW;

  logic signed [StateW-1:0]  speed_q, speed_d;
  logic signed [StateW-1:0]  target_fx;
  logic signed [StateW:0]    diff;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   step;
  logic signed [StateW:0]    sum;
  logic signed [ExtW-1:0]    drive_ext;

  always_comb begin
    target_fx = {target_i, {lwss_pkg::FracBits{1'b0}}};
    diff      = (StateW+1)'(target_fx) - (StateW+1)'(speed_q);
    prod      = ProdW'(diff) * ProdW'($signed({1'b0, alpha_i}));
    // floor division by 256
    step      = prod >>> lwss_pkg::FracBits;
    sum       = (StateW+1)'(speed_q) + step[StateW:0];
    speed_d   = enabled_i ? sum[StateW-1:0] : '0;
    drive_ext = ExtW'($signed(speed_d[StateW-1:lwss_pkg::FracBits]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (advance_i) begin
      speed_q <= speed_d;
    end
  end

  assign drive_o = drive_ext[lwss_pkg::DriveW-1:0];

endmodule

/* hw/rtl/link_watchdog_speed_smoother_core.sv */
// ----------------------------------------------------------------------------
// link_watchdog_speed_smoother_core: link watchdog and three-wheel smoother
// One control tick per input word: updates link quality and enable flag,
// then smooths the three wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per word: tdata holds the three wheel targets,
//   tuser the command-fresh flag. m_axis returns one word per tick: tdata
//   holds the three smoothed drives and the link quality, tuser the enable
//   flag after that tick.
//   The result passes through an input register, then the quality/filter
//   logic into the result register.
//   Throughput is one word per cycle while m_axis_tready is high; the input
//   register and result register form a two-deep pipeline, so a new word is
//   taken while a result waits.
//   When m_axis_tready is low, the result holds, the pending input holds and
//   s_axis_tready drops once both stages are full; no state advances until
//   the result register can take the next word.
//   The cfg channel is always ready; write registers only while idle.
//   Reset clears quality to zero, sets control enabled, clears the filter
//   states and loads the register defaults.
// ----------------------------------------------------------------------------
module link_watchdog_speed_smoother_core #(
  parameter int unsigned SPEED_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lwss_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [lwss_pkg::CfgDataW-1:0]        cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // target_m1, target_m2, target_m3, zero fill
  input  logic [((3*SPEED_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // command_fresh
  input  logic [0:0]                           s_axis_tuser_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // drive_m1, drive_m2, drive_m3, link_quality, zero fill
  output logic [lwss_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // control_enabled
  output logic [0:0]                           m_axis_tuser_o
);

  localparam int unsigned NW = lwss_pkg::NumWheels;

  lwss_pkg::cfg_t cfg_q;

  logic                         in_valid_q;
  logic                         fresh_q;
  logic signed [SPEED_BITS-1:0] target_q [NW];

  logic                             out_valid_q;
  logic [lwss_pkg::OutDataW-1:0]    out_data_q, out_data_d;
  logic                             out_enabled_q;

  logic                         advance;
  logic                         in_take;
  lwss_pkg::link_status_t       status;
  logic [lwss_pkg::AlphaW-1:0]  alpha_sat;
  logic [lwss_pkg::DriveW-1:0]  drive [NW];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lwss_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lwss_pkg::CFG_ALPHA:         cfg_q.alpha           <= cfg_data_i;
        lwss_pkg::CFG_QUALITY_FLOOR: cfg_q.quality_floor   <= cfg_data_i[lwss_pkg::LevelW-1:0];
        lwss_pkg::CFG_QUALITY_CEIL:  cfg_q.quality_ceiling <= cfg_data_i[lwss_pkg::LevelW-1:0];
        lwss_pkg::CFG_FRESH_BOOST:   cfg_q.fresh_boost     <= cfg_data_i[lwss_pkg::LevelW-1:0];
        lwss_pkg::CFG_DISABLE_LEVEL: cfg_q.disable_level   <= cfg_data_i[lwss_pkg::LevelW-1:0];
        lwss_pkg::CFG_ENABLE_LEVEL:  cfg_q.enable_level    <= cfg_data_i[lwss_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: advance when the result stage is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      fresh_q <= s_axis_tuser_i[0];
      for (int i = 0; i < NW; i++) begin
        target_q[i] <= s_axis_tdata_i[i*SPEED_BITS +: SPEED_BITS];
      end
    end
  end

  assign alpha_sat = lwss_pkg::sat_alpha(cfg_q.alpha);

  lwss_link_watch u_link_watch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .fresh_i   (fresh_q),
    .cfg_i     (cfg_q),
    .status_o  (status)
  );

  for (genvar w = 0; w < NW; w++) begin : g_lane
    lwss_filter_lane #(
      .SPEED_BITS (SPEED_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .enabled_i (status.enabled),
      .alpha_i   (alpha_sat),
      .target_i  (target_q[w]),
      .drive_o   (drive[w])
    );
  end

  assign out_data_d = {
    {(lwss_pkg::OutDataW - NW*lwss_pkg::DriveW - lwss_pkg::QualityW){1'b0}},
    status.quality, drive[2], drive[1], drive[0]
  };

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q    <= out_data_d;
      out_enabled_q <= status.enabled;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_enabled_q;

endmodule

/* test/link_watchdog_speed_smoother_checker.sv */
// ----------------------------------------------------------------------------
// link_watchdog_speed_smoother_checker: scoreboard for the speed smoother
// Watches the register write channel and both streams. It keeps its own copy
// of the link quality, enable flag, filter states and registers. It forecasts
// the result word of every accepted tick and compares each returned word,
// field by field, with the oldest forecast.
// ----------------------------------------------------------------------------
module link_watchdog_speed_smoother_checker
  import lwss_pkg::*;
#(
  parameter int unsigned SpeedBits = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIndexW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  // target_m1, target_m2, target_m3, zero fill
  input  logic [3*SpeedBits-1:0]   s_tdata_i,
  // command_fresh
  input  logic [0:0]               s_tuser_i,
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  // drive_m1, drive_m2, drive_m3, link_quality, zero fill
  input  logic [OutDataW-1:0]      m_tdata_i,
  // control_enabled
  input  logic [0:0]               m_tuser_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam int unsigned StateW = SpeedBits + FracBits;
  localparam int unsigned FillLo = NumWheels * DriveW + QualityW;

  // laid out as {tuser, tdata}: drives in the low bits, then quality, fill
  typedef struct packed {
    logic                             enabled;
    logic [OutDataW-FillLo-1:0]       fill;
    logic [QualityW-1:0]              quality;
    logic [NumWheels-1:0][DriveW-1:0] drive;
  } wheel_word_t;

  cfg_t                     regs;
  logic [QualityW-1:0]      quality_q;
  logic                     enabled_q;
  logic signed [StateW-1:0] speed_q [NumWheels];
  wheel_word_t              drive_forecast_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // One control tick: watchdog first, then the three filters.
  function automatic wheel_word_t advance_tick(input logic fresh,
                                               input logic [3*SpeedBits-1:0] targets);
    wheel_word_t w;
    int          q;
    longint      gain;
    longint      target_fx;
    longint      s;
    q = int'(quality_q) - 1;
    if (q >= int'(regs.quality_ceiling)) begin
      q = int'(regs.quality_ceiling);
    end else if (q <= int'(regs.quality_floor)) begin
      q = int'(regs.quality_floor);
    end
    if (fresh) begin
      q += int'(regs.fresh_boost);
    end
    quality_q = q[QualityW-1:0];
    if (q <= int'(regs.disable_level)) begin
      enabled_q = 1'b0;
    end else if (q >= int'(regs.enable_level)) begin
      enabled_q = 1'b1;
    end
    // weights above one saturate, so the filter jumps straight to its target
    gain = (regs.alpha > 9'd256) ? 64'sd256 : longint'(regs.alpha);
    w = '0;
    for (int k = 0; k < NumWheels; k++) begin
      if (!enabled_q) begin
        speed_q[k] = '0;
      end else begin
        target_fx  = longint'($signed(targets[k*SpeedBits +: SpeedBits])) * 256;
        s          = longint'(speed_q[k]);
        s          = s + ((gain * (target_fx - s)) >>> FracBits);
        speed_q[k] = s[StateW-1:0];
      end
      s         = longint'(speed_q[k]) >>> FracBits;
      w.drive[k] = s[DriveW-1:0];
    end
    w.enabled = enabled_q;
    w.quality = quality_q;
    return w;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_word_t want;
    wheel_word_t got;
    if (!rst_ni) begin
      regs = '{alpha: 9'd102, quality_floor: 8'd5, quality_ceiling: 8'd100,
               fresh_boost: 8'd30, disable_level: 8'd30, enable_level: 8'd70};
      quality_q = '0;
      enabled_q = 1'b1;
      for (int k = 0; k < NumWheels; k++) begin
        speed_q[k] = '0;
      end
      drive_forecast_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ALPHA:         regs.alpha           = cfg_data_i;
          CFG_QUALITY_FLOOR: regs.quality_floor   = cfg_data_i[LevelW-1:0];
          CFG_QUALITY_CEIL:  regs.quality_ceiling = cfg_data_i[LevelW-1:0];
          CFG_FRESH_BOOST:   regs.fresh_boost     = cfg_data_i[LevelW-1:0];
          CFG_DISABLE_LEVEL: regs.disable_level   = cfg_data_i[LevelW-1:0];
          CFG_ENABLE_LEVEL:  regs.enable_level    = cfg_data_i[LevelW-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i[0], m_tdata_i};
        if (drive_forecast_q.size() == 0) begin
          $error("result word with no tick outstanding: %h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = drive_forecast_q.pop_front();
          for (int k = 0; k < NumWheels; k++) begin
            compare_field($sformatf("drive_m%0d", k + 1),
                          longint'($signed(want.drive[k])),
                          longint'($signed(got.drive[k])));
          end
          compare_field("control_enabled", want.enabled, got.enabled);
          compare_field("link_quality", want.quality, got.quality);
          compare_field("zero fill", want.fill, got.fill);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        drive_forecast_q.push_back(advance_tick(s_tuser_i[0], s_tdata_i));
      end
      pending_o = drive_forecast_q.size();
    end
  end

endmodule

/* test/link_watchdog_speed_smoother_core_test.sv */
// ----------------------------------------------------------------------------
// link_watchdog_speed_smoother_core_test: stimulus and verdict
// Drives control ticks and register writes into the speed smoother, with
// random gaps on the input and random stalls on the output. A directed part
// covers target extremes, quality starting at zero, alpha above one, floor
// above ceiling and an unused register index; random phases then sweep the
// register settings and the command-fresh rate.
// ----------------------------------------------------------------------------
module link_watchdog_speed_smoother_core_test;
  import lwss_pkg::*;

  localparam int unsigned SpeedBits    = 16;
  localparam int unsigned InDataW      = ((3 * SpeedBits + 7) / 8) * 8;
  localparam int          QuietLimit   = 2000;
  localparam int          PhaseCount   = 10;
  localparam int          PhaseTicks   = 40;
  localparam logic [CfgIndexW-1:0] CfgUnusedIdx = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIndexW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;

  int   fail_count;
  int   pending;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  logic rx_took = 1'b0;
  int   rx_wait = 0;
  int   quiet_cycles = 0;

  logic [SpeedBits-1:0] extremes [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

  always #5 clk_i = ~clk_i;

  link_watchdog_speed_smoother_core #(.SPEED_BITS(SpeedBits)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  link_watchdog_speed_smoother_checker #(.SpeedBits(SpeedBits)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: while rx_idle is set, after each taken word hold ready low for a drawn stall.
  always @(posedge clk_i) begin
    rx_took <= m_axis_tvalid_o && m_tready;
  end

  always @(negedge clk_i) begin
    if (rx_took && rx_idle) begin
      rx_wait = $urandom_range(0, 4);
    end
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input logic fresh, input logic [SpeedBits-1:0] t1,
                           input logic [SpeedBits-1:0] t2, input logic [SpeedBits-1:0] t3);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t3, t2, t1};
    s_tuser  <= fresh;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  function automatic logic [SpeedBits-1:0] pick_target();
    case ($urandom_range(0, 7))
      0:       return extremes[$urandom_range(0, 4)];
      1:       return SpeedBits'($urandom_range(0, 31) - 16);
      default: return SpeedBits'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_level(input bit edge_case, input int lo,
                                                     input int hi);
    if (edge_case) begin
      return $urandom_range(0, 1) ? 9'd255 : 9'd0;
    end
    return CfgDataW'($urandom_range(lo, hi));
  endfunction

  task automatic random_config();
    bit                  edge_case;
    logic [CfgDataW-1:0] dis;
    logic [CfgDataW-1:0] alpha_pick [4] = '{9'd0, 9'd256, 9'd511, 9'd1};
    edge_case = ($urandom_range(0, 3) == 0);
    dis = pick_level(edge_case, 0, 60);
    write_reg(CFG_ALPHA, edge_case ? alpha_pick[$urandom_range(0, 3)]
                                   : CfgDataW'($urandom_range(0, 511)));
    write_reg(CFG_QUALITY_FLOOR, pick_level(edge_case, 0, 40));
    write_reg(CFG_QUALITY_CEIL, pick_level(edge_case, 60, 255));
    write_reg(CFG_FRESH_BOOST, pick_level(edge_case, 0, 80));
    write_reg(CFG_DISABLE_LEVEL, dis);
    write_reg(CFG_ENABLE_LEVEL, pick_level(edge_case, int'(dis), 200));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int fresh_pct;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults; quality starts at zero, extremes rotate across wheels.
    for (int i = 0; i < 14; i++) begin
      send_tick(i < 6 || i >= 11, extremes[i % 5], extremes[(i + 1) % 5],
                extremes[(i + 3) % 5]);
    end

    // Floor above ceiling, alpha saturated, unused index ignored.
    drain();
    write_reg(CFG_ALPHA, 9'd511);
    write_reg(CfgUnusedIdx, 9'd0);
    write_reg(CFG_QUALITY_FLOOR, 9'd200);
    write_reg(CFG_QUALITY_CEIL, 9'd50);
    write_reg(CFG_FRESH_BOOST, 9'd0);
    write_reg(CFG_DISABLE_LEVEL, 9'd60);
    write_reg(CFG_ENABLE_LEVEL, 9'd60);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      send_tick(i[0], extremes[i], extremes[4 - i], extremes[(i + 2) % 5]);
    end
    drain();
    write_reg(CFG_FRESH_BOOST, 9'd255);
    write_reg(CFG_ENABLE_LEVEL, 9'd255);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      send_tick(1'b1, extremes[(i + 1) % 5], extremes[i], extremes[4 - i]);
    end

    // Random phases: new settings, idling mode and fresh rate each time.
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      random_config();
      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      fresh_pct = (p % 3 == 0) ? 10 : ((p % 3 == 1) ? 90 : 50);
      repeat (PhaseTicks) begin
        send_tick($urandom_range(0, 99) < fresh_pct, pick_target(), pick_target(),
                  pick_target());
      end
    end

    drain();
    repeat (6) @(negedge clk_i);
    if (pending != 0) begin
      $error("%0d result words never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lwss_pkg.sv
hw/rtl/lwss_link_watch.sv
hw/rtl/lwss_filter_lane.sv
hw/rtl/link_watchdog_speed_smoother_core.sv
test/link_watchdog_speed_smoother_checker.sv
test/link_watchdog_speed_smoother_core_test.sv
